@@ hw/rtl/b2da_pkg.sv @@
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and controller/datapath interface types for the
// binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_W            = 32;
    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int MAX_DIGITS         = 10;
    localparam int DIGIT_W            = 4;
    localparam int BCD_BITS           = MAX_DIGITS * DIGIT_W;
    localparam int DIG_CNT_W          = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_W             = 6;

    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
    localparam logic [1:0]         ASCII_HIGH   = 2'b11;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift_digit;
    } b2da_cmd_t;

    typedef struct packed {
        logic bit_last;
        logic digit_last;
    } b2da_status_t;

endpackage

@@ hw/rtl/b2da_ctrl.sv @@
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: load, one shift-add pass per input bit, then digit emission.
// ----------------------------------------------------------------------------
module b2da_ctrl
    import b2da_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output b2da_cmd_t    cmd,
    input  b2da_status_t status
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CONVERT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.dabble = 1'b1;
                if (status.bit_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.shift_digit = 1'b1;
                if (status.digit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/b2da_datapath.sv @@
// ----------------------------------------------------------------------------
// b2da_datapath
// Double dabble shift register, bcd digit shifter and output register.
// ----------------------------------------------------------------------------
module b2da_datapath
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] value,
    input  b2da_cmd_t          cmd,
    output b2da_status_t       status,
    output logic               strobe,
    output logic [CHAR_W-1:0]  char_code,
    output logic               last_digit
);

    localparam int EFF_BITS  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int BIT_CNT_W = $clog2(EFF_BITS + 1);

    logic [EFF_BITS-1:0]  bin_reg;
    logic [BCD_BITS-1:0]  bcd_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;
    logic                 started_reg;
    logic                 strobe_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;

    logic [BCD_BITS-1:0]  adjusted;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 emit;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT)
            begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end
            else
            begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit         = bcd_reg[BCD_BITS-1 -: DIGIT_W];
    assign status.bit_last   = (bit_cnt_reg == BIT_CNT_W'(1));
    assign status.digit_last = (dig_cnt_reg == DIG_CNT_W'(1));

    // leading zeros are skipped, the final digit always goes out
    assign emit = cmd.shift_digit
                  && ((top_digit != '0) || started_reg || status.digit_last);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg     <= value[EFF_BITS-1:0];
            bcd_reg     <= '0;
            bit_cnt_reg <= BIT_CNT_W'(EFF_BITS);
            dig_cnt_reg <= DIG_CNT_W'(MAX_DIGITS);
        end
        else if (cmd.dabble)
        begin
            bin_reg     <= bin_reg << 1;
            bcd_reg     <= {adjusted[BCD_BITS-2:0], bin_reg[EFF_BITS-1]};
            bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
        end
        else if (cmd.shift_digit)
        begin
            bcd_reg     <= bcd_reg << DIGIT_W;
            dig_cnt_reg <= dig_cnt_reg - DIG_CNT_W'(1);
        end
        if (emit)
        begin
            char_reg <= {ASCII_HIGH, top_digit};
            last_reg <= status.digit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
            if (cmd.load)
            begin
                started_reg <= 1'b0;
            end
            else if (emit)
            begin
                started_reg <= 1'b1;
            end
        end
    end

    assign strobe     = strobe_reg;
    assign char_code  = char_reg;
    assign last_digit = last_reg;

endmodule

@@ hw/rtl/binary_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts an unsigned binary value into decimal ascii digit characters.
// ----------------------------------------------------------------------------
// usage:
//   drive value and raise start while busy is low; that edge takes the
//   transaction and busy rises on the next cycle.
//   the converter runs one shift-add-3 pass per input bit (VALUE_BITS passes,
//   capped at 32), then walks the ten bcd digits from the top, one per cycle,
//   skipping leading zeros.
//   each digit leaves as a one-cycle strobe with char_code ('0'..'9') and
//   last_digit set on the least significant digit. zero gives a single '0'.
//   a transaction runs the bit-serial conversion loop and then the digit walk;
//   the first digit appears after the conversion loop, later when leading
//   zeros are skipped.
//   busy falls on the edge that registers the last digit, so the next start
//   may overlap the final strobe.
//   there is no backpressure: results must be taken when strobe is high.
//   reset clears the sequencer and the strobe; any transaction in flight
//   is dropped.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic               strobe,
    output logic [CHAR_W-1:0]  char_code,
    output logic               last_digit
);

    b2da_cmd_t    cmd;
    b2da_status_t status;

    b2da_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    b2da_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .strobe     (strobe),
        .char_code  (char_code),
        .last_digit (last_digit)
    );

endmodule

@@ bench/binary_to_decimal_ascii_top_test.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top_test
// Self-checking bench for the binary to decimal ascii converter: feeds
// directed and random 32-bit values through the start/busy handshake with
// random gaps and back-to-back bursts, predicts the digit characters of each
// value and checks every strobed digit in order.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top_test
    import b2da_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 410;
    localparam int          MAX_GAP      = 12;
    localparam int          SETTLE_CYCLES = 50;
    localparam int          IDLE_LIMIT   = 1000;
    localparam logic [5:0]  ASCII_ZERO   = 6'h30;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_digit;
    } digit_char_t;

    class ascii_digit_ledger;
        digit_char_t expected_chars[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // split into decimal digits, then queue them most significant first
        function void note_value(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] rest;
            logic [DIGIT_W-1:0] digs[MAX_DIGITS];
            int                 n;
            digit_char_t        item;
            rest = v;
            n    = 0;
            do
            begin
                digs[n] = DIGIT_W'(rest % 10);
                rest    = rest / 10;
                n++;
            end while (rest != 0 && n < MAX_DIGITS);
            for (int k = n - 1; k >= 0; k--)
            begin
                item.char_code  = ASCII_ZERO | CHAR_W'(digs[k]);
                item.last_digit = (k == 0);
                expected_chars.push_back(item);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            digit_char_t want;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected digit: char_code %0d last_digit %0d", code, last);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (code !== want.char_code)
            begin
                $error("char_code mismatch: expected %0d, actual %0d", want.char_code, code);
                errors++;
            end
            if (last !== want.last_digit)
            begin
                $error("last_digit mismatch: expected %0d, actual %0d",
                       want.last_digit, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [VALUE_W-1:0] value = '0;
    logic               strobe;
    logic [CHAR_W-1:0]  char_code;
    logic               last_digit;

    ascii_digit_ledger ledger = new();
    int                idle_cycles = 0;
    bit                burst_mode = 1'b0;

    binary_to_decimal_ascii_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .char_code  (char_code),
        .last_digit (last_digit)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
                ledger.note_value(value);
            if (strobe)
                ledger.check_char(char_code, last_digit);
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one transaction; start stays high afterwards so back-to-back items
    // never drop it within a time step
    task automatic send_value(logic [VALUE_W-1:0] v);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // step one edge first so the monitor has noted the last accepted transaction
    task automatic wait_for_drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (ledger.pending() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned p;
        int              k;
        p = 1;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                // uniform over a random digit count
                k = $urandom_range(1, MAX_DIGITS);
                for (int i = 1; i < k; i++)
                    p = p * 10;
                lo = (k == 1) ? 0 : p;
                hi = p * 10 - 1;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                return VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
            end
            2:
            begin
                // around a power of ten, where the digit count changes
                k = $urandom_range(0, MAX_DIGITS - 1);
                for (int i = 0; i < k; i++)
                    p = p * 10;
                return VALUE_W'(p + $urandom_range(0, 2) - 1);
            end
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial
    begin
        logic [VALUE_W-1:0] directed[$];
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'hFFFF_FFFF,
                     32'hFFFF_FFFE, 32'd999999999, 32'd1000000000, 32'd1000000001,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'd4000000000, 32'd12345,
                     32'd100000, 32'd10000000, 32'd1234567890, 32'd3999999999,
                     32'h5555_5555, 32'hAAAA_AAAA};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_value(directed[i]);
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // alternate stretches of random gaps with back-to-back bursts
            if (n % 40 == 20)
                burst_mode = 1'b1;
            else if (n % 40 == 0)
                burst_mode = 1'b0;
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
            send_value(pick_value());
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
